// File: sv/dfcp_pkg.sv
// shared types and byte codes for the dle framed card info parser
`default_nettype none

package dfcp_pkg;

  localparam logic [7:0] DLE_BYTE = 8'h10;
  localparam logic [7:0] SYN_BYTE = 8'h16;
  localparam logic [7:0] ETX_BYTE = 8'h03;

  // captured payload header length and trailer limits
  localparam int unsigned HDR_LEN = 18;
  localparam int unsigned CNT_W   = 5;
  localparam logic [CNT_W-1:0] HDR_LEN_C = CNT_W'(HDR_LEN);
  localparam logic [1:0] TRL_MIN = 2'd2;
  localparam logic [1:0] TRL_SAT = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } in_t;

  typedef struct packed {
    logic        valid_res;
    logic [7:0]  dest_addr;
    logic [7:0]  service_code;
    logic [7:0]  seq_counter;
    logic [7:0]  source_addr;
    logic [7:0]  ack_code;
    logic [15:0] atqa;
    logic [7:0]  cascade_tag;
    logic [55:0] uid;
    logic [7:0]  bcc1;
    logic [7:0]  bcc2;
    logic [7:0]  sak;
  } out_t;

endpackage

`default_nettype wire

// File: sv/dfcp_in_reg.sv
// input register stage, holds one byte until the deframer takes it
`default_nettype none

module dfcp_in_reg
  import dfcp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  input  wire logic res_busy,
  output logic      step,
  output in_t       item
);

  logic v_r, v_nxt;
  in_t  data_r;

  // a last byte waits while the previous result is still unclaimed
  assign step     = v_r && !(data_r.frame_end && res_busy);
  assign in_ready = !v_r || step;
  assign item     = data_r;

  always_comb begin
    v_nxt = v_r;
    if (in_ready) begin
      v_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

endmodule

`default_nettype wire

// File: sv/dfcp_deframe.sv
// frame state machine, dle destuffing and header capture
`default_nettype none

module dfcp_deframe
  import dfcp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic step,
  input  wire in_t  item,
  output logic      res_load,
  output out_t      res_data
);

  localparam logic [1:0] MODE_HUNT = 2'd0;
  localparam logic [1:0] MODE_PAY  = 2'd1;
  localparam logic [1:0] MODE_TRL  = 2'd2;
  localparam logic [1:0] MODE_FAIL = 2'd3;

  logic [1:0]       mode_r, mode_nxt;
  logic             prev_r, prev_nxt;
  logic             esc_r, esc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       trl_r, trl_nxt;
  logic [7:0]       pay_r [HDR_LEN];

  logic [1:0]       mode_upd;
  logic             prev_upd, esc_upd;
  logic [CNT_W-1:0] cnt_upd;
  logic [1:0]       trl_upd;
  logic             push, wr_en, ok;
  logic [7:0]       b;

  assign b = item.data_byte;

  always_comb begin
    mode_upd = mode_r;
    prev_upd = prev_r;
    esc_upd  = esc_r;
    trl_upd  = trl_r;
    push     = 1'b0;
    unique case (mode_r)
      MODE_HUNT: begin
        if (prev_r && b == SYN_BYTE) begin
          mode_upd = MODE_PAY;
          prev_upd = 1'b0;
          esc_upd  = 1'b0;
        end else begin
          prev_upd = (b == DLE_BYTE);
        end
      end
      MODE_PAY: begin
        if (prev_r && b == ETX_BYTE) begin
          // only a raw dle may close the payload
          mode_upd = esc_r ? MODE_TRL : MODE_FAIL;
          trl_upd  = 2'd0;
        end else if (esc_r) begin
          if (b == DLE_BYTE) begin
            push     = 1'b1;
            esc_upd  = 1'b0;
            prev_upd = 1'b1;
          end else begin
            mode_upd = MODE_FAIL;
          end
        end else if (b == DLE_BYTE) begin
          esc_upd  = 1'b1;
          prev_upd = 1'b1;
        end else begin
          push     = 1'b1;
          prev_upd = 1'b0;
        end
      end
      MODE_TRL: begin
        if (trl_r < TRL_SAT) begin
          trl_upd = trl_r + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

  assign wr_en   = push && (cnt_r < HDR_LEN_C);
  assign cnt_upd = wr_en ? cnt_r + CNT_W'(1) : cnt_r;

  // a pushing byte never ends in trailer mode, so the stored bytes are complete here
  assign ok = (mode_upd == MODE_TRL) && (trl_upd >= TRL_MIN) && (cnt_upd >= HDR_LEN_C);

  assign res_load = step && item.frame_end;

  always_comb begin
    res_data              = '0;
    res_data.valid_res    = ok;
    if (ok) begin
      res_data.dest_addr    = pay_r[0];
      res_data.service_code = pay_r[1];
      res_data.seq_counter  = pay_r[2];
      res_data.source_addr  = pay_r[3];
      res_data.ack_code     = pay_r[4];
      res_data.atqa         = {pay_r[5], pay_r[6]};
      res_data.cascade_tag  = pay_r[7];
      res_data.uid          = {pay_r[8], pay_r[9], pay_r[10], pay_r[12],
                               pay_r[13], pay_r[14], pay_r[15]};
      res_data.bcc1         = pay_r[11];
      res_data.bcc2         = pay_r[16];
      res_data.sak          = pay_r[17];
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    prev_nxt = prev_r;
    esc_nxt  = esc_r;
    cnt_nxt  = cnt_r;
    trl_nxt  = trl_r;
    if (step) begin
      if (item.frame_end) begin
        mode_nxt = MODE_HUNT;
        prev_nxt = 1'b0;
        esc_nxt  = 1'b0;
        cnt_nxt  = '0;
        trl_nxt  = 2'd0;
      end else begin
        mode_nxt = mode_upd;
        prev_nxt = prev_upd;
        esc_nxt  = esc_upd;
        cnt_nxt  = cnt_upd;
        trl_nxt  = trl_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_HUNT;
      prev_r <= 1'b0;
      esc_r  <= 1'b0;
      cnt_r  <= '0;
      trl_r  <= 2'd0;
    end else begin
      mode_r <= mode_nxt;
      prev_r <= prev_nxt;
      esc_r  <= esc_nxt;
      cnt_r  <= cnt_nxt;
      trl_r  <= trl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && wr_en) begin
      pay_r[cnt_r] <= b;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= HDR_LEN_C)
    else $error("payload count beyond header length");

  a_trl_mode: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r != MODE_TRL |-> trl_r == 2'd0)
    else $error("trailer count outside trailer mode");

  a_esc_prev: assert property (@(posedge clk) disable iff (!rst_n)
    esc_r |-> prev_r)
    else $error("escape pending without raw dle");

  a_hunt_empty: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_HUNT |-> (cnt_r == '0 && !esc_r))
    else $error("payload state left over while hunting");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> (mode_r == MODE_HUNT && cnt_r == '0 && !prev_r))
    else $error("state not cleared after last byte");

endmodule

`default_nettype wire

// File: sv/dfcp_out_reg.sv
// result register, holds one result until the receiver takes it
`default_nettype none

module dfcp_out_reg
  import dfcp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic res_load,
  input  wire out_t res_data,
  output logic      res_busy,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  logic v_r, v_nxt;
  out_t data_r;

  assign res_busy  = v_r && !out_ready;
  assign out_valid = v_r;
  assign out_data  = data_r;

  always_comb begin
    v_nxt = res_load || res_busy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      data_r <= res_data;
    end
  end

endmodule

`default_nettype wire

// File: sv/dle_framed_card_info_parser.sv
// top level of the dle framed card info parser
// usage:
//   in_valid/in_ready/in_data carry one raw frame byte per transfer, with
//   frame_end set on the last byte of the frame buffer
//   out_valid/out_ready/out_data carry one result per frame, given only for
//   the byte marked frame_end; valid_res low means framing or length failure
//   and then every other field reads zero
// path: a last byte accepted into the input register is processed there by
//   the frame state machine, and its result is loaded into the result register
//   and shows on out_valid (input register, then result register)
// throughput: one byte per cycle unless a last byte waits on a held result,
//   set by one pass through the frame state machine between the two registers
// stall: while a result waits on out_ready, ordinary bytes keep flowing;
//   a further last byte is held in the input register and in_ready stays low
//   behind it until the cycle in which the waiting result transfer completes
// reset: rst_n low clears both valid flags and puts the parser back to
//   hunting for the start pair; captured payload bytes are not cleared
`default_nettype none

module dle_framed_card_info_parser
  import dfcp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  // handshake between the stages
  logic step;
  in_t  item;
  logic res_load;
  out_t res_data;
  logic res_busy;

  // input register, lets the deframer see a registered byte
  dfcp_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .res_busy (res_busy),
    .step     (step),
    .item     (item)
  );

  // frame state machine and header capture
  dfcp_deframe u_deframe (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .item     (item),
    .res_load (res_load),
    .res_data (res_data)
  );

  // result register toward the receiver
  dfcp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_load  (res_load),
    .res_data  (res_data),
    .res_busy  (res_busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
